@@ rtl/mdtu_pkg.sv @@
// mdtu_pkg: command codes, register indexes and address constants of the multidrop node
package mdtu_pkg;

    // command codes carried in tuser
    localparam logic [2:0] CMD_FRAME_RX = 3'd0;
    localparam logic [2:0] CMD_SLOT_FREE = 3'd1;
    localparam logic [2:0] CMD_TX_DONE = 3'd2;
    localparam logic [2:0] CMD_HOST_PUSH = 3'd3;
    localparam logic [2:0] CMD_HOST_POP = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_STATION_ID = 2'd0;
    localparam logic [1:0] REG_BROADCAST_ID = 2'd1;

    localparam int unsigned ADDR_W = 7;
    localparam int unsigned TOKEN_BIT = 7;
    localparam logic [ADDR_W-1:0] BROADCAST_RESET = 7'h7F;

    typedef struct packed {
        logic       tx_accepted;
        logic       rx_overflow;
        logic [7:0] rx_data;
        logic       rx_valid;
        logic       token_request;
        logic       driver_enable;
        logic [7:0] line_out_data;
        logic       line_out_valid;
    } t_result;

endpackage

@@ rtl/multidrop_token_uart_node.sv @@
// multidrop_token_uart_node: 9-bit multidrop bus node with token passing and rx/tx rings
// an accepted item passes the input register, then the result register, where its result is valid
// one item per cycle unless stalled; rings read at most once per item, registered into the result
// a stalled result holds the next item in the input register; input stalls once both are full
// reset: synchronous, active low; clears flags, pointers, counts and ids (station 0, broadcast 127)
// ring contents are not cleared: entries are only read after they have been written
module multidrop_token_uart_node
    import mdtu_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // frame_data[7:0], host_byte[15:8]
    input  logic [3:0]  i_s_tuser,   // command[2:0], frame_ninth[3]
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // line_out_valid[0], line_out_data[8:1], driver_enable[9],
                                     // token_request[10], rx_valid[11], rx_data[19:12],
                                     // rx_overflow[20], tx_accepted[21], zero[23:22]
    output logic [0:0]  o_m_tuser,   // line_out_ninth[0]
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    localparam int unsigned PTR_W = $clog2(BUFFER_DEPTH);
    localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

    // configuration
    logic [ADDR_W-1:0] r_station_id;
    logic [ADDR_W-1:0] r_broadcast_id;

    // input register
    logic       r_in_valid;
    logic [2:0] r_cmd;
    logic [7:0] r_fdata;
    logic       r_fninth;
    logic [7:0] r_hbyte;

    // node state
    logic r_listening, n_listening;
    logic r_sending, n_sending;
    logic r_token_sent, n_token_sent;
    logic r_driver_on, n_driver_on;

    logic [PTR_W-1:0] r_rx_wr_ptr, n_rx_wr_ptr;
    logic [PTR_W-1:0] r_rx_rd_ptr, n_rx_rd_ptr;
    logic [CNT_W-1:0] r_rx_count, n_rx_count;
    logic [PTR_W-1:0] r_tx_wr_ptr, n_tx_wr_ptr;
    logic [PTR_W-1:0] r_tx_rd_ptr, n_tx_rd_ptr;
    logic [CNT_W-1:0] r_tx_count, n_tx_count;

    logic [7:0] r_rx_mem [BUFFER_DEPTH];
    logic [7:0] r_tx_mem [BUFFER_DEPTH];
    logic [7:0] r_rx_rdata;
    logic [7:0] r_tx_rdata;

    // result register
    logic       r_out_valid;
    t_result    r_res;
    logic       r_ninth;
    t_result    out_res;

    // decoded item
    logic       fire;
    logic       rx_wr;
    logic       tx_wr;
    logic       rx_pop;
    logic       tx_pop;
    t_result    n_res;
    logic       n_ninth;
    logic       addr_hit;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign fire        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;
    assign addr_hit    = (r_fdata[ADDR_W-1:0] == r_station_id)
                      || (r_fdata[ADDR_W-1:0] == r_broadcast_id);

    always_comb begin
        n_listening  = r_listening;
        n_sending    = r_sending;
        n_token_sent = r_token_sent;
        n_driver_on  = r_driver_on;
        n_rx_wr_ptr  = r_rx_wr_ptr;
        n_rx_rd_ptr  = r_rx_rd_ptr;
        n_rx_count   = r_rx_count;
        n_tx_wr_ptr  = r_tx_wr_ptr;
        n_tx_rd_ptr  = r_tx_rd_ptr;
        n_tx_count   = r_tx_count;
        rx_wr        = 1'b0;
        tx_wr        = 1'b0;
        rx_pop       = 1'b0;
        tx_pop       = 1'b0;
        n_res        = '0;
        n_ninth      = 1'b0;
        unique case (r_cmd)
            CMD_FRAME_RX: begin
                if (r_fninth) begin
                    n_listening = addr_hit;
                    if (addr_hit && r_fdata[TOKEN_BIT]) begin
                        n_res.token_request = 1'b1;
                        // idle is simply not sending
                        if (!r_sending) begin
                            n_driver_on = 1'b1;
                            n_sending   = 1'b1;
                        end
                    end
                end else if (r_listening) begin
                    if (r_rx_count < CNT_FULL) begin
                        rx_wr       = 1'b1;
                        n_rx_wr_ptr = ptr_inc(r_rx_wr_ptr);
                        n_rx_count  = r_rx_count + 1'b1;
                    end else begin
                        n_res.rx_overflow = 1'b1;
                    end
                end
            end
            CMD_SLOT_FREE: begin
                if (r_sending) begin
                    if (r_tx_count != '0) begin
                        tx_pop               = 1'b1;
                        n_res.line_out_valid = 1'b1;
                        n_tx_rd_ptr          = ptr_inc(r_tx_rd_ptr);
                        n_tx_count           = r_tx_count - 1'b1;
                    end else if (!r_token_sent) begin
                        n_token_sent         = 1'b1;
                        n_res.line_out_valid = 1'b1;
                        n_res.line_out_data  = {1'b0, r_station_id};
                        n_ninth              = 1'b1;
                    end else begin
                        n_sending    = 1'b0;
                        n_token_sent = 1'b0;
                    end
                end
            end
            CMD_TX_DONE: begin
                if (!r_sending) begin
                    n_driver_on = 1'b0;
                end
            end
            CMD_HOST_PUSH: begin
                if (r_tx_count < CNT_FULL) begin
                    tx_wr             = 1'b1;
                    n_tx_wr_ptr       = ptr_inc(r_tx_wr_ptr);
                    n_tx_count        = r_tx_count + 1'b1;
                    n_res.tx_accepted = 1'b1;
                end
            end
            CMD_HOST_POP: begin
                if (r_rx_count != '0) begin
                    rx_pop         = 1'b1;
                    n_res.rx_valid = 1'b1;
                    n_rx_rd_ptr    = ptr_inc(r_rx_rd_ptr);
                    n_rx_count     = r_rx_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_res.driver_enable = n_driver_on;
    end

    // ring memories: at most one write or one registered read each per transaction
    always_ff @(posedge i_clk) begin
        if (fire && rx_wr) begin
            r_rx_mem[r_rx_wr_ptr] <= r_fdata;
        end
        if (fire && tx_wr) begin
            r_tx_mem[r_tx_wr_ptr] <= r_hbyte;
        end
        if (fire && rx_pop) begin
            r_rx_rdata <= r_rx_mem[r_rx_rd_ptr];
        end
        if (fire && tx_pop) begin
            r_tx_rdata <= r_tx_mem[r_tx_rd_ptr];
        end
    end

    // payload of the result register
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res   <= n_res;
            r_ninth <= n_ninth;
        end
    end

    // ring bytes join the result; a sent frame without the ninth bit came from the tx ring
    always_comb begin
        out_res = r_res;
        if (r_res.line_out_valid && !r_ninth) begin
            out_res.line_out_data = r_tx_rdata;
        end
        if (r_res.rx_valid) begin
            out_res.rx_data = r_rx_rdata;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_cmd    <= i_s_tuser[2:0];
            r_fninth <= i_s_tuser[3];
            r_fdata  <= i_s_tdata[7:0];
            r_hbyte  <= i_s_tdata[15:8];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_id   <= '0;
            r_broadcast_id <= BROADCAST_RESET;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_listening    <= 1'b0;
            r_sending      <= 1'b0;
            r_token_sent   <= 1'b0;
            r_driver_on    <= 1'b0;
            r_rx_wr_ptr    <= '0;
            r_rx_rd_ptr    <= '0;
            r_rx_count     <= '0;
            r_tx_wr_ptr    <= '0;
            r_tx_rd_ptr    <= '0;
            r_tx_count     <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_STATION_ID) begin
                    r_station_id <= i_cfg_data;
                end else if (i_cfg_index == REG_BROADCAST_ID) begin
                    r_broadcast_id <= i_cfg_data;
                end
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                r_listening  <= n_listening;
                r_sending    <= n_sending;
                r_token_sent <= n_token_sent;
                r_driver_on  <= n_driver_on;
                r_rx_wr_ptr  <= n_rx_wr_ptr;
                r_rx_rd_ptr  <= n_rx_rd_ptr;
                r_rx_count   <= n_rx_count;
                r_tx_wr_ptr  <= n_tx_wr_ptr;
                r_tx_rd_ptr  <= n_tx_rd_ptr;
                r_tx_count   <= n_tx_count;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, out_res};
    assign o_m_tuser  = r_ninth;

`ifndef SYNTHESIS
    a_rx_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_count <= CNT_FULL)
        else $error("rx ring count beyond depth");

    a_tx_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_count <= CNT_FULL)
        else $error("tx ring count beyond depth");

    a_token_in_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_token_sent |-> r_sending)
        else $error("end token marked outside a send");

    a_driver_in_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sending |-> r_driver_on)
        else $error("sending with line driver released");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_cmd == CMD_HOST_POP && r_rx_count != '0) |=> (r_out_valid && r_res.rx_valid))
        else $error("pop from non-empty ring gave no byte");
`endif

endmodule
